// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent implies consequent (use |-> or |=> inside the property).
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/dfsp_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame sync parser package
// Types, constants and header classification shared by the parser modules.
// ----------------------------------------------------------------------------
package dfsp_pkg;

	typedef logic [7:0] byte_t;

	localparam byte_t SYNC_BYTE = 8'h5A;

	// Scan phases of the byte hunter
	typedef enum logic [1:0] {
		PH_HUNT   = 2'd0,
		PH_HDR1   = 2'd1,
		PH_HDR2   = 2'd2,
		PH_GATHER = 2'd3
	} scan_phase_t;

	// Accepted frame kinds
	typedef enum logic [1:0] {
		KIND_HEAD = 2'd0,
		KIND_BODY = 2'd1,
		KIND_TAIL = 2'd2
	} frame_kind_t;

	// Header type codes and frame lengths
	localparam logic [1:0]  TYPE_HEAD = 2'd2;
	localparam logic [1:0]  TYPE_BODY = 2'd0;
	localparam logic [1:0]  TYPE_TAIL = 2'd1;
	localparam logic [12:0] LEN_HEAD  = 13'd20;
	localparam logic [12:0] LEN_BODY  = 13'd17;
	localparam logic [12:0] LEN_TAIL  = 13'd12;
	localparam logic [12:0] AMP_BASE  = 13'd4096;

	// Input beat
	typedef struct packed {
		byte_t stream_byte;
	} stream_beat_t;

	// Result beat
	typedef struct packed {
		logic [1:0]  frame_kind;
		logic [31:0] event_number;
		logic [47:0] timestamp_ticks;
		logic [6:0]  channel_count;
		logic [5:0]  frontend_id;
		logic [6:0]  channel_number;
		logic [23:0] baseline_raw;
		logic [12:0] amplitude;
	} frame_beat_t;

	// Header classification
	typedef struct packed {
		logic        ok;
		frame_kind_t kind;
	} hdr_class_t;

	// Scanner to result stage
	typedef struct packed {
		logic        done;
		frame_kind_t kind;
	} scan_evt_t;

	function automatic hdr_class_t classify(input byte_t h1, input byte_t h2);
		logic [1:0]  typ;
		logic [12:0] len;
		hdr_class_t  c;
		typ = h1[6:5];
		len = {h1[4:0], h2};
		c.ok = 1'b1;
		c.kind = KIND_HEAD;
		if (typ == TYPE_HEAD && len == LEN_HEAD) begin
			c.kind = KIND_HEAD;
		end else if (typ == TYPE_BODY && len == LEN_BODY) begin
			c.kind = KIND_BODY;
		end else if (typ == TYPE_TAIL && len == LEN_TAIL) begin
			c.kind = KIND_TAIL;
		end else begin
			c.ok = 1'b0;
		end
		return c;
	endfunction

	function automatic logic [4:0] kind_len(input frame_kind_t k);
		logic [4:0] n;
		unique case (k)
			KIND_HEAD: n = LEN_HEAD[4:0];
			KIND_BODY: n = LEN_BODY[4:0];
			KIND_TAIL: n = LEN_TAIL[4:0];
			default:   n = LEN_TAIL[4:0];
		endcase
		return n;
	endfunction

endpackage

// ===== design/dfsp_stream_if.sv =====
// ----------------------------------------------------------------------------
// Stream channel interface
// Valid/ready channel carrying one payload beat of type T.
// ----------------------------------------------------------------------------
interface dfsp_stream_if #(
	parameter type T = logic [7:0]
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== design/dfsp_input_reg.sv =====
// ----------------------------------------------------------------------------
// Frame sync parser input register
// Registers each incoming byte beat; refills in the cycle it is consumed.
// ----------------------------------------------------------------------------
module dfsp_input_reg (
	input  logic           clk,
	input  logic           arst_n,
	dfsp_stream_if.sink    stream,
	input  logic           take,
	output logic           valid_s1,
	output dfsp_pkg::byte_t byte_s1
);
	import dfsp_pkg::*;

	// Accept when empty or when the held beat leaves this cycle
	assign stream.ready = !valid_s1 || take;

	// Hold valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	// Capture payload
	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1 <= stream.data.stream_byte;
		end
	end
endmodule

// ===== design/dfsp_scanner.sv =====
// ----------------------------------------------------------------------------
// Frame sync parser scanner
// Hunts for the sync byte, checks the header and gathers frame bytes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dfsp_scanner #(
	parameter int MAX_FRAME_BYTES = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  dfsp_pkg::byte_t     byte_s1,
	output dfsp_pkg::scan_evt_t evt,
	output dfsp_pkg::byte_t     store_q [MAX_FRAME_BYTES]
);
	import dfsp_pkg::*;

	localparam int TW = $clog2(MAX_FRAME_BYTES + 1);
	localparam int IW = $clog2(MAX_FRAME_BYTES);

	scan_phase_t    phase_q, phase_d;
	byte_t          hdr1_q;
	logic [TW-1:0]  taken_q;
	frame_kind_t    kind_q;

	hdr_class_t     hdr;
	logic [TW-1:0]  taken_inc;
	logic           frame_end;

	// Header and gather bookkeeping
	assign hdr       = classify(hdr1_q, byte_s1);
	assign taken_inc = taken_q + TW'(1);
	assign frame_end = taken_inc >= TW'(kind_len(kind_q));

	// Next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == SYNC_BYTE) phase_d = PH_HDR1;
			end
			PH_HDR1: begin
				phase_d = PH_HDR2;
			end
			PH_HDR2: begin
				if (hdr.ok) phase_d = PH_GATHER;
				else if (hdr1_q == SYNC_BYTE) phase_d = PH_HDR2;
				else if (byte_s1 == SYNC_BYTE) phase_d = PH_HDR1;
				else phase_d = PH_HUNT;
			end
			PH_GATHER: begin
				if (frame_end) phase_d = PH_HUNT;
			end
			default: phase_d = PH_HUNT;
		endcase
	end

	// Completion event
	always_comb begin
		evt.done = 1'b0;
		evt.kind = kind_q;
		unique case (phase_q)
			PH_GATHER: evt.done = step && frame_end;
			default:   evt.done = 1'b0;
		endcase
	end

	// Advance phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
		end else if (step) begin
			phase_q <= phase_d;
		end
	end

	// Track header byte, gather count and kind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr1_q  <= '0;
			taken_q <= '0;
			kind_q  <= KIND_HEAD;
		end else if (step) begin
			if (phase_q == PH_HDR1) begin
				hdr1_q <= byte_s1;
			end else if (phase_q == PH_HDR2) begin
				if (hdr.ok) begin
					taken_q <= TW'(3);
					kind_q  <= hdr.kind;
				end else if (hdr1_q == SYNC_BYTE) begin
					hdr1_q <= byte_s1;
				end
			end else if (phase_q == PH_GATHER) begin
				taken_q <= frame_end ? '0 : taken_inc;
			end
		end
	end

	// Fill frame store
	always_ff @(posedge clk) begin
		if (step) begin
			if (phase_q == PH_HDR2 && hdr.ok) begin
				store_q[0] <= SYNC_BYTE;
				store_q[1] <= hdr1_q;
				store_q[2] <= byte_s1;
			end else if (phase_q == PH_GATHER) begin
				store_q[taken_q[IW-1:0]] <= byte_s1;
			end
		end
	end

	`ASSERT_IMPLY(a_count_idle, phase_q != PH_GATHER, taken_q == '0, "count not clear")
	`ASSERT_IMPLY(a_count_bound, phase_q == PH_GATHER,
		taken_q < TW'(kind_len(kind_q)) && taken_q >= TW'(3), "count out of frame")
	`ASSERT_NEXT(a_done_hunt, evt.done, phase_q == PH_HUNT, "no hunt after frame")
endmodule

// ===== design/dfsp_result_reg.sv =====
// ----------------------------------------------------------------------------
// Frame sync parser result register
// Decodes the finished frame from the store and holds the result beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dfsp_result_reg #(
	parameter int MAX_FRAME_BYTES = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  dfsp_pkg::scan_evt_t evt,
	input  dfsp_pkg::byte_t     store_q [MAX_FRAME_BYTES],
	output logic                can_take,
	dfsp_stream_if.source       frame
);
	import dfsp_pkg::*;

	frame_beat_t res;
	frame_beat_t res_q;
	logic        valid_q;
	logic        load;

	// Room for a new beat when empty or draining
	assign can_take = !valid_q || frame.ready;
	assign load     = step && evt.done;

	// Decode fields by kind; absent fields stay zero
	always_comb begin
		res = '0;
		res.frame_kind = evt.kind;
		case (evt.kind)
			KIND_HEAD: begin
				res.event_number    = {store_q[10], store_q[11], store_q[12], store_q[13]};
				res.timestamp_ticks = {store_q[4], store_q[5], store_q[6],
					store_q[7], store_q[8], store_q[9]};
				res.channel_count   = store_q[14][6:0];
			end
			KIND_BODY: begin
				res.frontend_id    = store_q[3][5:0];
				res.channel_number = store_q[4][6:0];
				res.baseline_raw   = {store_q[6], store_q[7], store_q[8]};
				res.amplitude      = AMP_BASE - {1'b0, store_q[9][3:0], store_q[10]};
			end
			default: begin
				res.event_number = {store_q[4], store_q[5], store_q[6], store_q[7]};
			end
		endcase
	end

	// Hold valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (frame.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Capture payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign frame.valid = valid_q;
	assign frame.data  = res_q;

	`ASSERT_IMPLY(a_no_overwrite, load, !valid_q || frame.ready, "result overwritten")
	`ASSERT_NEXT(a_load_shows, load, valid_q, "loaded result not shown")
	`ASSERT_ALWAYS(a_kind_legal, !valid_q || res_q.frame_kind != 2'd3, "bad kind out")
endmodule

// ===== design/detector_frame_sync_parser_unit.sv =====
// ----------------------------------------------------------------------------
// Detector frame sync parser
// Scans a byte stream for sync 0x5A, checks head/body/tail headers, gathers
// each frame and emits one decoded result beat per completed frame.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Beat                 | Notes
//  stream   | in  | stream_byte (8 bit)  | one raw byte per beat
//  frame    | out | decoded frame fields | one beat per completed frame
//
// One byte per cycle sustained while no result waits on a stalled frame; a
// byte is parsed after acceptance (input register to scanner) and its result
// shows on the next edge, held in the result register.
// Reset clears the scan state and both valid flags; the frame store is not
// cleared, every field is read only after it is written within its frame.
// A stall on frame holds the scanner only while a result is waiting.
// ----------------------------------------------------------------------------
module detector_frame_sync_parser_unit #(
	parameter int MAX_FRAME_BYTES = 20
) (
	input  logic          clk,
	input  logic          arst_n,
	dfsp_stream_if.sink   stream,
	dfsp_stream_if.source frame
);
	import dfsp_pkg::*;

	logic      valid_s1;
	byte_t     byte_s1;
	logic      can_take;
	logic      step;
	scan_evt_t evt;
	byte_t     store_q [MAX_FRAME_BYTES];

	// Parse the held byte when the result side has room
	assign step = valid_s1 && can_take;

	dfsp_input_reg u_input (
		.clk      (clk),
		.arst_n   (arst_n),
		.stream   (stream),
		.take     (step),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	dfsp_scanner #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_scanner (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_s1 (byte_s1),
		.evt     (evt),
		.store_q (store_q)
	);

	dfsp_result_reg #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.evt      (evt),
		.store_q  (store_q),
		.can_take (can_take),
		.frame    (frame)
	);
endmodule

// ===== tb/detector_frame_sync_parser_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Frame sync parser testbench
// Feeds raw byte beats with head, body and tail frames, broken headers and
// noise, decodes every accepted byte in a local parser model and checks each
// decoded frame beat field by field against the oldest predicted frame.
// ----------------------------------------------------------------------------
module detector_frame_sync_parser_unit_tb;

	import dfsp_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned STREAM_BYTES  = 1400;
	localparam int unsigned HOLD_START    = 500;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned DRAIN_CYCLES  = 20;
	localparam int unsigned PRINT_LIMIT   = 40;

	logic clk = 1'b0;
	logic arst_n;

	dfsp_stream_if #(.T(stream_beat_t)) byte_if ();
	dfsp_stream_if #(.T(frame_beat_t))  frame_if ();

	detector_frame_sync_parser_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (byte_if),
		.frame  (frame_if)
	);

	// Stimulus backlog and predicted frames
	byte_t       byte_backlog[$];
	frame_beat_t predicted_frames[$];

	int unsigned mismatch_count = 0;
	int unsigned bytes_accepted = 0;
	int unsigned cycles = 0;
	int unsigned send_gap = 0;
	int unsigned recv_gap = 0;
	bit          calm = 1'b0;
	bit          hold_off = 1'b0;

	// Local parser state
	scan_phase_t hunt_phase = PH_HUNT;
	byte_t       hdr_lead = '0;
	int unsigned gathered = 0;
	frame_kind_t gather_kind = KIND_HEAD;
	byte_t       frame_bytes [0:19];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Mostly short gaps, a few long ones; none during calm stretches
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic byte_t payload_byte();
		int unsigned r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return SYNC_BYTE;
		if (r == 1)
			return 8'h00;
		if (r == 2)
			return 8'hFF;
		return byte_t'($urandom_range(0, 255));
	endfunction

	// Decode one accepted byte; queue a frame when it completes one
	task automatic parse_byte(input byte_t b);
		logic [1:0]  typ;
		logic [12:0] flen;
		bit          ok;
		frame_kind_t k;
		int unsigned need;
		frame_beat_t r;
		typ = hdr_lead[6:5];
		flen = {hdr_lead[4:0], b};
		ok = 1'b1;
		k = KIND_HEAD;
		need = 0;
		r = '0;
		case (hunt_phase)
			PH_HUNT: begin
				if (b == SYNC_BYTE)
					hunt_phase = PH_HDR1;
			end
			PH_HDR1: begin
				hdr_lead = b;
				hunt_phase = PH_HDR2;
			end
			PH_HDR2: begin
				if (typ == TYPE_HEAD && flen == LEN_HEAD)
					k = KIND_HEAD;
				else if (typ == TYPE_BODY && flen == LEN_BODY)
					k = KIND_BODY;
				else if (typ == TYPE_TAIL && flen == LEN_TAIL)
					k = KIND_TAIL;
				else
					ok = 1'b0;
				if (ok) begin
					frame_bytes[0] = SYNC_BYTE;
					frame_bytes[1] = hdr_lead;
					frame_bytes[2] = b;
					gathered = 3;
					gather_kind = k;
					hunt_phase = PH_GATHER;
				end else if (hdr_lead == SYNC_BYTE) begin
					// second sync byte restarts the header
					hdr_lead = b;
				end else if (b == SYNC_BYTE) begin
					hunt_phase = PH_HDR1;
				end else begin
					hunt_phase = PH_HUNT;
				end
			end
			default: begin
				frame_bytes[gathered] = b;
				gathered++;
				case (gather_kind)
					KIND_HEAD: need = 32'(LEN_HEAD);
					KIND_BODY: need = 32'(LEN_BODY);
					default:   need = 32'(LEN_TAIL);
				endcase
				if (gathered >= need) begin
					r.frame_kind = gather_kind;
					case (gather_kind)
						KIND_HEAD: begin
							r.event_number = {frame_bytes[10], frame_bytes[11],
								frame_bytes[12], frame_bytes[13]};
							r.timestamp_ticks = {frame_bytes[4], frame_bytes[5],
								frame_bytes[6], frame_bytes[7], frame_bytes[8],
								frame_bytes[9]};
							r.channel_count = frame_bytes[14][6:0];
						end
						KIND_BODY: begin
							r.frontend_id = frame_bytes[3][5:0];
							r.channel_number = frame_bytes[4][6:0];
							r.baseline_raw = {frame_bytes[6], frame_bytes[7],
								frame_bytes[8]};
							r.amplitude = AMP_BASE - {1'b0, frame_bytes[9][3:0],
								frame_bytes[10]};
						end
						default: begin
							r.event_number = {frame_bytes[4], frame_bytes[5],
								frame_bytes[6], frame_bytes[7]};
						end
					endcase
					predicted_frames.push_back(r);
					gathered = 0;
					hunt_phase = PH_HUNT;
				end
			end
		endcase
	endtask

	task automatic flag_mismatch(input string what, input logic [63:0] want,
		input logic [63:0] got);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("mismatch at cycle %0d, %s: expected %0h, got %0h",
				cycles, what, want, got);
	endtask

	task automatic check_frame(input frame_beat_t got);
		frame_beat_t want;
		if (predicted_frames.size() == 0) begin
			flag_mismatch("frame beat with none predicted", '0, 64'(got.frame_kind));
		end else begin
			want = predicted_frames.pop_front();
			if (got.frame_kind != want.frame_kind)
				flag_mismatch("frame_kind", 64'(want.frame_kind), 64'(got.frame_kind));
			if (got.event_number != want.event_number)
				flag_mismatch("event_number", 64'(want.event_number),
					64'(got.event_number));
			if (got.timestamp_ticks != want.timestamp_ticks)
				flag_mismatch("timestamp_ticks", 64'(want.timestamp_ticks),
					64'(got.timestamp_ticks));
			if (got.channel_count != want.channel_count)
				flag_mismatch("channel_count", 64'(want.channel_count),
					64'(got.channel_count));
			if (got.frontend_id != want.frontend_id)
				flag_mismatch("frontend_id", 64'(want.frontend_id),
					64'(got.frontend_id));
			if (got.channel_number != want.channel_number)
				flag_mismatch("channel_number", 64'(want.channel_number),
					64'(got.channel_number));
			if (got.baseline_raw != want.baseline_raw)
				flag_mismatch("baseline_raw", 64'(want.baseline_raw),
					64'(got.baseline_raw));
			if (got.amplitude != want.amplitude)
				flag_mismatch("amplitude", 64'(want.amplitude), 64'(got.amplitude));
		end
	endtask

	// Append a frame; fill below zero means random payload
	task automatic push_frame(input frame_kind_t k, input int fill, input bit with_sync);
		byte_t       lead;
		byte_t       trail;
		int unsigned total;
		lead = (fill < 0) ? byte_t'($urandom_range(0, 1) << 7) : byte_t'(fill & 8'h80);
		case (k)
			KIND_HEAD: begin
				lead[6:5] = TYPE_HEAD;
				lead[4:0] = LEN_HEAD[12:8];
				trail = LEN_HEAD[7:0];
				total = 32'(LEN_HEAD);
			end
			KIND_BODY: begin
				lead[6:5] = TYPE_BODY;
				lead[4:0] = LEN_BODY[12:8];
				trail = LEN_BODY[7:0];
				total = 32'(LEN_BODY);
			end
			default: begin
				lead[6:5] = TYPE_TAIL;
				lead[4:0] = LEN_TAIL[12:8];
				trail = LEN_TAIL[7:0];
				total = 32'(LEN_TAIL);
			end
		endcase
		if (with_sync)
			byte_backlog.push_back(SYNC_BYTE);
		byte_backlog.push_back(lead);
		byte_backlog.push_back(trail);
		for (int unsigned i = 3; i < total; i++)
			byte_backlog.push_back((fill < 0) ? payload_byte() : byte_t'(fill));
	endtask

	// Append a sync byte and a header that misses one accepted form, or random bytes
	task automatic push_broken_header();
		frame_kind_t k;
		byte_t       lead;
		byte_t       trail;
		k = frame_kind_t'($urandom_range(0, 2));
		lead = byte_t'($urandom_range(0, 1) << 7);
		case (k)
			KIND_HEAD: begin
				lead[6:5] = TYPE_HEAD;
				trail = LEN_HEAD[7:0];
			end
			KIND_BODY: begin
				lead[6:5] = TYPE_BODY;
				trail = LEN_BODY[7:0];
			end
			default: begin
				lead[6:5] = TYPE_TAIL;
				trail = LEN_TAIL[7:0];
			end
		endcase
		case ($urandom_range(0, 3))
			0: trail = trail ^ byte_t'(1 << $urandom_range(0, 7));
			1: lead[4:0] = 5'($urandom_range(1, 31));
			2: lead[6:5] = 2'd3;
			default: begin
				lead = byte_t'($urandom_range(0, 255));
				trail = byte_t'($urandom_range(0, 255));
			end
		endcase
		byte_backlog.push_back(SYNC_BYTE);
		byte_backlog.push_back(lead);
		byte_backlog.push_back(trail);
	endtask

	// Drive byte beats from the backlog; predict each accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_if.valid <= 1'b0;
			byte_if.data <= '0;
			send_gap <= 0;
		end else begin
			if (byte_if.valid && byte_if.ready) begin
				parse_byte(byte_if.data.stream_byte);
				bytes_accepted++;
			end
			if (byte_if.valid && !byte_if.ready) begin
				// hold the current beat
			end else if (send_gap != 0 && !hold_off) begin
				send_gap <= send_gap - 1;
				byte_if.valid <= 1'b0;
			end else if (byte_backlog.size() != 0) begin
				byte_if.valid <= 1'b1;
				byte_if.data <= '{stream_byte: byte_backlog.pop_front()};
				send_gap <= hold_off ? 0 : pick_gap();
			end else begin
				byte_if.valid <= 1'b0;
			end
		end
	end

	// Accept and check frame beats with random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_if.ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (frame_if.valid && frame_if.ready)
				check_frame(frame_if.data);
			if (hold_off) begin
				frame_if.ready <= 1'b0;
			end else if (recv_gap != 0) begin
				recv_gap <= recv_gap - 1;
				frame_if.ready <= 1'b0;
			end else begin
				frame_if.ready <= 1'b1;
				recv_gap <= ($urandom_range(0, 7) == 0) ? pick_gap() : 0;
			end
		end
	end

	// Count cycles, switch calm stretches, stop on a hang
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles[7:0] == 8'd0)
			calm <= ($urandom_range(0, 3) == 0);
		if (cycles == CYCLE_LIMIT) begin
			$display("[detector_frame_sync_parser_unit] ERROR");
			$finish;
		end
	end

	// Hold off the frame side long enough to back up the byte side
	initial begin
		wait (bytes_accepted >= HOLD_START);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		frame_kind_t k;
		int unsigned pick;
		arst_n = 1'b0;

		// Directed: noise, header recovery cases, field extremes
		byte_backlog.push_back(8'h00);
		byte_backlog.push_back(8'hFF);
		// rejected header falls back to hunting
		byte_backlog.push_back(SYNC_BYTE);
		byte_backlog.push_back(8'h40);
		byte_backlog.push_back(8'h15);
		// repeated sync byte, body header follows
		byte_backlog.push_back(SYNC_BYTE);
		push_frame(KIND_BODY, 'h00, 1'b1);
		// sync byte as second header byte starts a new header
		byte_backlog.push_back(SYNC_BYTE);
		byte_backlog.push_back(8'h01);
		push_frame(KIND_HEAD, 'hFF, 1'b1);
		// back-to-back frames, sync bytes inside the payload
		push_frame(KIND_TAIL, int'(SYNC_BYTE), 1'b1);
		push_frame(KIND_BODY, 'hFF, 1'b1);
		push_frame(KIND_HEAD, 'h00, 1'b1);
		push_frame(KIND_TAIL, 'hFF, 1'b1);

		// Random: mostly well-formed frames, some noise and broken headers
		while (byte_backlog.size() < STREAM_BYTES) begin
			pick = $urandom_range(0, 99);
			k = frame_kind_t'($urandom_range(0, 2));
			if (pick < 70) begin
				push_frame(k, -1, 1'b1);
			end else if (pick < 82) begin
				repeat ($urandom_range(1, 5)) byte_backlog.push_back(payload_byte());
			end else if (pick < 94) begin
				push_broken_header();
			end else begin
				byte_backlog.push_back(SYNC_BYTE);
				push_frame(k, -1, 1'b1);
			end
		end
		// close any frame a broken header may have opened
		repeat (20) byte_backlog.push_back(8'h00);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: all beats accepted, all frames seen, then settle
		while (byte_backlog.size() != 0 || byte_if.valid)
			@(posedge clk);
		while (predicted_frames.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[detector_frame_sync_parser_unit] OK");
		end else begin
			$display("[detector_frame_sync_parser_unit] ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/dfsp_pkg.sv
design/dfsp_stream_if.sv
design/dfsp_input_reg.sv
design/dfsp_scanner.sv
design/dfsp_result_reg.sv
design/detector_frame_sync_parser_unit.sv
tb/detector_frame_sync_parser_unit_tb.sv
